FILE: sv/c3lf_pkg.sv
// c3lf_pkg: shared types, constants and helpers of the 3x3 line filter
`default_nettype none

package c3lf_pkg;

    localparam int PIX_W       = 8;
    localparam int COL_W       = 3 * PIX_W;
    localparam int TAP_W       = 16;
    localparam int COEF_W      = 3 * TAP_W;
    localparam int ROUND_SHIFT = 12;
    localparam int PROD_W      = PIX_W + TAP_W + 1;
    localparam int ROW_W       = PROD_W + 2;
    localparam int SUM_W       = ROW_W + 3;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_COEFF_TOP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_MID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_BOT = 2'd2;

    localparam logic [COEF_W-1:0] COEFF_TOP_RST = 48'h0;
    localparam logic [COEF_W-1:0] COEFF_MID_RST = 48'h0000_1000_0000;
    localparam logic [COEF_W-1:0] COEFF_BOT_RST = 48'h0;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    typedef logic [COL_W-1:0]           col_t;
    typedef logic [2:0][COEF_W-1:0]     coef_rows_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ROW_W-1:0]    row_sum_t;
    typedef logic signed [SUM_W-1:0]    sum_t;

    // one filter request: left, center and right columns plus result flags
    typedef struct packed {
        col_t col_l;
        col_t col_c;
        col_t col_r;
        logic run_last;
        logic line_last;
    } job_t;

    function automatic logic [PIX_W-1:0] pix_of(col_t col, logic [1:0] line);
        return col[line*PIX_W +: PIX_W];
    endfunction

    function automatic logic signed [TAP_W-1:0] tap_of(logic [COEF_W-1:0] row,
                                                       logic [1:0] k);
        return $signed(row[k*TAP_W +: TAP_W]);
    endfunction

    function automatic prod_t mul_tap(logic [PIX_W-1:0] p, logic signed [TAP_W-1:0] t);
        prod_t pe;
        prod_t te;
        pe = $signed({{(PROD_W-PIX_W){1'b0}}, p});
        te = PROD_W'(t);
        return pe * te;
    endfunction

endpackage

`default_nettype wire

FILE: sv/c3lf_fifo.sv
// c3lf_fifo: short request queue between the column front end and the filter datapath
`default_nettype none

module c3lf_fifo
    import c3lf_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_data,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output job_t      head_data
);

    job_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign full       = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("request pushed into full queue");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count out of range");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule

`default_nettype wire

FILE: sv/c3lf_front.sv
// c3lf_front: column window tracking and filter request generation
`default_nettype none

module c3lf_front
    import c3lf_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [PIX_W-1:0] s_pix_top,
    input  wire logic [PIX_W-1:0] s_pix_mid,
    input  wire logic [PIX_W-1:0] s_pix_bot,
    input  wire logic             s_line_end,
    input  wire logic             q_full,
    output logic                  q_push,
    output job_t                  q_data
);

    col_t       col_prev_reg, col_prev_next;
    col_t       col_prev2_reg, col_prev2_next;
    logic [1:0] cols_seen_reg, cols_seen_next;
    logic       pend_reg, pend_next;
    logic       accept;
    col_t       col_in;
    col_t       left;

    assign col_in  = {s_pix_bot, s_pix_mid, s_pix_top};
    assign s_ready = !pend_reg && !q_full;
    assign accept  = s_valid && s_ready;
    assign left    = (cols_seen_reg == 2'd1) ? col_prev_reg : col_prev2_reg;

    // state update
    always_comb begin
        col_prev_next  = col_prev_reg;
        col_prev2_next = col_prev2_reg;
        cols_seen_next = cols_seen_reg;
        pend_next      = pend_reg;
        if (pend_reg && !q_full) begin
            pend_next = 1'b0;
        end
        if (accept) begin
            if (cols_seen_reg == 2'd0) begin
                if (!s_line_end) begin
                    col_prev_next  = col_in;
                    cols_seen_next = 2'd1;
                end
            end else begin
                col_prev2_next = col_prev_reg;
                col_prev_next  = col_in;
                cols_seen_next = s_line_end ? 2'd0 : 2'd2;
                pend_next      = s_line_end;
            end
        end
    end

    // request generation; the trailing edge request uses the updated window
    always_comb begin
        q_push = 1'b0;
        q_data = '{col_l: col_in, col_c: col_in, col_r: col_in,
                   run_last: 1'b1, line_last: 1'b1};
        if (pend_reg) begin
            q_push = !q_full;
            q_data = '{col_l: col_prev2_reg, col_c: col_prev_reg, col_r: col_prev_reg,
                       run_last: 1'b1, line_last: 1'b1};
        end else if (accept) begin
            if (cols_seen_reg == 2'd0) begin
                q_push = s_line_end;
            end else begin
                q_push = 1'b1;
                q_data = '{col_l: left, col_c: col_prev_reg, col_r: col_in,
                           run_last: !s_line_end, line_last: 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_prev_reg  <= '0;
            col_prev2_reg <= '0;
            cols_seen_reg <= '0;
            pend_reg      <= 1'b0;
        end else begin
            col_prev_reg  <= col_prev_next;
            col_prev2_reg <= col_prev2_next;
            cols_seen_reg <= cols_seen_next;
            pend_reg      <= pend_next;
        end
    end

    a_pend_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> !s_ready)
        else $error("input accepted while edge request pending");

    a_cols_seen_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cols_seen_reg != 2'd3)
        else $error("column count out of range");

    a_pend_after_line_end: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> cols_seen_reg == 2'd0)
        else $error("edge request pending mid line");

endmodule

`default_nettype wire

FILE: sv/c3lf_back.sv
// c3lf_back: pipelined 3x3 multiply, sum, round and clamp with output register
`default_nettype none

module c3lf_back
    import c3lf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire coef_rows_t  coefs,
    input  wire logic        q_valid,
    input  wire job_t        q_data,
    output logic             q_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [PIX_W-1:0] m_out_pixel,
    output logic             m_run_last,
    output logic             m_line_last
);

    localparam sum_t ROUND_ADD = sum_t'(1) <<< (ROUND_SHIFT - 1);

    logic                 adv;
    col_t                 cols [3];
    prod_t [2:0][2:0]     prod_next;
    prod_t [2:0][2:0]     s1_prod_reg;
    logic                 s1_valid_reg;
    logic                 s1_run_reg, s1_last_reg;
    row_sum_t [2:0]       row_next;
    row_sum_t [2:0]       s2_row_reg;
    logic                 s2_valid_reg;
    logic                 s2_run_reg, s2_last_reg;
    sum_t                 total;
    sum_t                 shifted;
    logic [PIX_W-1:0]     pix_next;
    logic                 out_valid_reg;
    logic [PIX_W-1:0]     out_pix_reg;
    logic                 out_run_reg, out_last_reg;

    assign adv   = !out_valid_reg || m_ready;
    assign q_pop = adv && q_valid;

    assign cols[0] = q_data.col_l;
    assign cols[1] = q_data.col_c;
    assign cols[2] = q_data.col_r;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod_next[r][c] = mul_tap(pix_of(cols[c], 2'(r)), tap_of(coefs[r], 2'(c)));
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            row_next[r] = row_sum_t'(s1_prod_reg[r][0]) + row_sum_t'(s1_prod_reg[r][1])
                        + row_sum_t'(s1_prod_reg[r][2]);
        end
    end

    // round, shift and clamp to pixel range
    always_comb begin
        total = sum_t'(s2_row_reg[0]) + sum_t'(s2_row_reg[1]) + sum_t'(s2_row_reg[2])
              + ROUND_ADD;
        shifted = total >>> ROUND_SHIFT;
        if (total[SUM_W-1]) begin
            pix_next = '0;
        end else if (|shifted[SUM_W-1:PIX_W]) begin
            pix_next = PIX_MAX;
        end else begin
            pix_next = shifted[PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= q_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_prod_reg  <= prod_next;
            s1_run_reg   <= q_data.run_last;
            s1_last_reg  <= q_data.line_last;
            s2_row_reg   <= row_next;
            s2_run_reg   <= s1_run_reg;
            s2_last_reg  <= s1_last_reg;
            out_pix_reg  <= pix_next;
            out_run_reg  <= s2_run_reg;
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_out_pixel = out_pix_reg;
    assign m_run_last  = out_run_reg;
    assign m_line_last = out_last_reg;

    a_pop_only_on_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (q_valid && adv))
        else $error("queue popped while pipeline stalled");

    a_stall_holds_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (!adv && s2_valid_reg) |=> s2_valid_reg)
        else $error("pipeline stage lost during stall");

    a_line_last_is_run_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_last_reg) |-> out_run_reg)
        else $error("line end result without run end flag");

endmodule

`default_nettype wire

FILE: sv/conv3x3_line_filter.sv
// conv3x3_line_filter: streaming 3x3 convolution over three image lines
//
//   channel  ports                                           direction
//   s_       s_valid/s_ready, pix_top/mid/bot, line_end      in  (one column)
//   m_       m_valid/m_ready, out_pixel, run_last, line_last out (one pixel)
//   cfg_     cfg_wr_en, cfg_index, cfg_wdata                 in  (coefficient rows)
//
// one column per cycle while the queue is not full; a line-end column after earlier
// columns stalls input until its two requests are in the single-issue request queue
// a request passes through the queue, the product and row sum registers and the
// output register before its result appears
// reset is synchronous, clears window and queue, loads the identity kernel
// the four-deep queue lets input continue while the output side stalls
`default_nettype none

module conv3x3_line_filter
    import c3lf_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [PIX_W-1:0]     s_pix_top,
    input  wire logic [PIX_W-1:0]     s_pix_mid,
    input  wire logic [PIX_W-1:0]     s_pix_bot,
    input  wire logic                 s_line_end,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [PIX_W-1:0]          m_out_pixel,
    output logic                      m_run_last,
    output logic                      m_line_last,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COEF_W-1:0]    cfg_wdata
);

    coef_rows_t coef_reg;
    logic       q_full;
    logic       q_push;
    job_t       q_wdata;
    logic       q_pop;
    logic       q_valid;
    job_t       q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[0] <= COEFF_TOP_RST;
            coef_reg[1] <= COEFF_MID_RST;
            coef_reg[2] <= COEFF_BOT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_COEFF_TOP: coef_reg[0] <= cfg_wdata;
                REG_COEFF_MID: coef_reg[1] <= cfg_wdata;
                REG_COEFF_BOT: coef_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    c3lf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pix_top  (s_pix_top),
        .s_pix_mid  (s_pix_mid),
        .s_pix_bot  (s_pix_bot),
        .s_line_end (s_line_end),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    c3lf_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_wdata),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    c3lf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .coefs       (coef_reg),
        .q_valid     (q_valid),
        .q_data      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_pixel (m_out_pixel),
        .m_run_last  (m_run_last),
        .m_line_last (m_line_last)
    );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// tb_top: self-checking stream test of the 3x3 line filter with its own kernel predictor
`timescale 1ns / 100ps

module tb_top;
    import c3lf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYC  = 8;
    localparam int ITEMS_PER_PHASE = 240;
    localparam int NUM_PHASES  = 8;

    typedef enum bit {ROW_COLUMN, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [COEF_W-1:0]      data;
        logic [PIX_W-1:0]       top, mid, bot;
        logic                   eol;
        bit                     typed;
        logic [PIX_W-1:0]       p0, p1;
    } dir_row_t;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             run_last;
        logic             line_last;
    } px_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [PIX_W-1:0]     s_pix_top = '0;
    logic [PIX_W-1:0]     s_pix_mid = '0;
    logic [PIX_W-1:0]     s_pix_bot = '0;
    logic                 s_line_end = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [PIX_W-1:0]     m_out_pixel;
    logic                 m_run_last;
    logic                 m_line_last;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0]    cfg_wdata = '0;

    // predictor state
    logic [COEF_W-1:0] kern_top = COEFF_TOP_RST;
    logic [COEF_W-1:0] kern_mid = COEFF_MID_RST;
    logic [COEF_W-1:0] kern_bot = COEFF_BOT_RST;
    logic [COL_W-1:0]  win_prev = '0;
    logic [COL_W-1:0]  win_prev2 = '0;
    int                win_fill = 0;

    px_result_t px_due[$];
    px_result_t head_px;
    int         n_err = 0;
    int         quiet_cyc = 0;
    int         src_idle_pct = 0;
    int         sink_stall_pct = 0;

    conv3x3_line_filter DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pix_top   (s_pix_top),
        .s_pix_mid   (s_pix_mid),
        .s_pix_bot   (s_pix_bot),
        .s_line_end  (s_line_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_pixel (m_out_pixel),
        .m_run_last  (m_run_last),
        .m_line_last (m_line_last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [COEF_W-1:0] taps3(logic [TAP_W-1:0] l, logic [TAP_W-1:0] c,
                                                logic [TAP_W-1:0] r);
        return {r, c, l};
    endfunction

    function automatic logic [PIX_W-1:0] apply_kernel(logic [COL_W-1:0] l, logic [COL_W-1:0] c,
                                                      logic [COL_W-1:0] r);
        logic [COL_W-1:0]  cols [3];
        logic [COEF_W-1:0] rows [3];
        longint            acc;
        cols[0] = l;
        cols[1] = c;
        cols[2] = r;
        rows[0] = kern_top;
        rows[1] = kern_mid;
        rows[2] = kern_bot;
        acc = 0;
        for (int ln = 0; ln < 3; ln++) begin
            for (int k = 0; k < 3; k++) begin
                acc += longint'($signed(rows[ln][k*TAP_W +: TAP_W]))
                     * longint'(cols[k][ln*PIX_W +: PIX_W]);
            end
        end
        acc += longint'(1) <<< (ROUND_SHIFT - 1);
        if (acc < 0)
            return '0;
        acc = acc >>> ROUND_SHIFT;
        return (acc > 255) ? PIX_MAX : acc[PIX_W-1:0];
    endfunction

    // update window state and queue the pixels this column produces
    function automatic void predict_column(logic [PIX_W-1:0] t, logic [PIX_W-1:0] m,
                                           logic [PIX_W-1:0] b, logic eol, bit typed,
                                           logic [PIX_W-1:0] p0, logic [PIX_W-1:0] p1);
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] left;
        px_result_t       res;
        col = {b, m, t};
        if (win_fill == 0) begin
            if (eol) begin
                res.pix = typed ? p0 : apply_kernel(col, col, col);
                res.run_last = 1'b1;
                res.line_last = 1'b1;
                px_due.push_back(res);
            end else begin
                win_prev = col;
                win_fill = 1;
            end
        end else begin
            left = (win_fill == 1) ? win_prev : win_prev2;
            res.pix = typed ? p0 : apply_kernel(left, win_prev, col);
            res.run_last = !eol;
            res.line_last = 1'b0;
            px_due.push_back(res);
            if (eol) begin
                res.pix = typed ? p1 : apply_kernel(win_prev, col, col);
                res.run_last = 1'b1;
                res.line_last = 1'b1;
                px_due.push_back(res);
            end
            win_prev2 = win_prev;
            win_prev = col;
            win_fill = eol ? 0 : 2;
        end
    endfunction

    function automatic dir_row_t dir_col(logic [PIX_W-1:0] t, logic [PIX_W-1:0] m,
                                         logic [PIX_W-1:0] b, logic eol, bit typed,
                                         logic [PIX_W-1:0] p0, logic [PIX_W-1:0] p1);
        dir_row_t r;
        r = '{ROW_COLUMN, '0, '0, t, m, b, eol, typed, p0, p1};
        return r;
    endfunction

    function automatic dir_row_t dir_wr(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
        dir_row_t r;
        r = '{ROW_WRITE, idx, data, '0, '0, '0, 1'b0, 1'b0, '0, '0};
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pix();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 20)
            return PIX_MAX;
        return PIX_W'($urandom());
    endfunction

    function automatic logic [TAP_W-1:0] rand_tap();
        int r;
        r = $urandom_range(99);
        if (r < 20)
            return TAP_W'($urandom());
        if (r < 25)
            return 16'h7FFF;
        if (r < 30)
            return 16'h8000;
        return TAP_W'(int'($urandom_range(2400)) - 1200);
    endfunction

    // assumes the caller stands at a falling edge
    task automatic send_col(input logic [PIX_W-1:0] t, input logic [PIX_W-1:0] m,
                            input logic [PIX_W-1:0] b, input logic eol, input bit typed,
                            input logic [PIX_W-1:0] p0, input logic [PIX_W-1:0] p1);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pix_top <= t;
        s_pix_mid <= m;
        s_pix_bot <= b;
        s_line_end <= eol;
        do @(posedge aclk); while (!s_ready);
        predict_column(t, m, b, eol, typed, p0, p1);
        @(negedge aclk);
    endtask

    task automatic drain_idle();
        s_valid <= 1'b0;
        while (px_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYC) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_COEFF_TOP: kern_top = data;
            REG_COEFF_MID: kern_mid = data;
            REG_COEFF_BOT: kern_bot = data;
            default: ;
        endcase
    endtask

    task automatic send_lines(input int n_items);
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 15)
                len = 1;
            else if (r < 30)
                len = 2;
            else if (r < 85)
                len = $urandom_range(3, 8);
            else
                len = $urandom_range(9, 40);
            for (int i = 0; i < len; i++)
                send_col(rand_pix(), rand_pix(), rand_pix(), i == len - 1, 1'b0, '0, '0);
            sent += len;
        end
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (px_due.size() == 0) begin
                $error("unexpected result: out_pixel %0d run_last %0b line_last %0b",
                       m_out_pixel, m_run_last, m_line_last);
                n_err++;
            end else begin
                head_px = px_due.pop_front();
                if (m_out_pixel !== head_px.pix) begin
                    $error("out_pixel: expected %0d, got %0d", head_px.pix, m_out_pixel);
                    n_err++;
                end
                if (m_run_last !== head_px.run_last) begin
                    $error("run_last: expected %0b, got %0b", head_px.run_last, m_run_last);
                    n_err++;
                end
                if (m_line_last !== head_px.line_last) begin
                    $error("line_last: expected %0b, got %0b", head_px.line_last, m_line_last);
                    n_err++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
            quiet_cyc = 0;
        else
            quiet_cyc++;
        if (quiet_cyc >= QUIET_LIMIT) begin
            $display("** conv3x3_line_filter: FAILED **");
            $finish;
        end
    end

    initial begin
        dir_row_t dir_tab[$];
        int       mode;

        // identity kernel after reset: result is the center pixel
        dir_tab.push_back(dir_col(8'd0, 8'd255, 8'd0, 1'b1, 1'b1, 8'd255, 8'd0));
        dir_tab.push_back(dir_col(8'd1, 8'd0, 8'd2, 1'b0, 1'b1, 8'd0, 8'd0));
        dir_tab.push_back(dir_col(8'd3, 8'd255, 8'd4, 1'b0, 1'b1, 8'd0, 8'd0));
        dir_tab.push_back(dir_col(8'd5, 8'd128, 8'd6, 1'b1, 1'b1, 8'd255, 8'd128));
        // large sum saturates high, zero input rounds to zero
        dir_tab.push_back(dir_wr(REG_COEFF_TOP, taps3(16'h7FFF, 16'h7FFF, 16'h7FFF)));
        dir_tab.push_back(dir_wr(REG_COEFF_MID, taps3(16'h7FFF, 16'h7FFF, 16'h7FFF)));
        dir_tab.push_back(dir_wr(REG_COEFF_BOT, taps3(16'h7FFF, 16'h7FFF, 16'h7FFF)));
        dir_tab.push_back(dir_col(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 8'd255, 8'd0));
        dir_tab.push_back(dir_col(8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 8'd0, 8'd0));
        // negative sum clamps to zero
        dir_tab.push_back(dir_wr(REG_COEFF_TOP, taps3(16'h8000, 16'h8000, 16'h8000)));
        dir_tab.push_back(dir_wr(REG_COEFF_MID, taps3(16'h8000, 16'h8000, 16'h8000)));
        dir_tab.push_back(dir_wr(REG_COEFF_BOT, taps3(16'h8000, 16'h8000, 16'h8000)));
        dir_tab.push_back(dir_col(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 8'd0, 8'd0));
        // write to an unmapped index leaves the identity kernel alone
        dir_tab.push_back(dir_wr(REG_COEFF_TOP, COEFF_TOP_RST));
        dir_tab.push_back(dir_wr(REG_COEFF_MID, COEFF_MID_RST));
        dir_tab.push_back(dir_wr(REG_COEFF_BOT, COEFF_BOT_RST));
        dir_tab.push_back(dir_wr(REG_NONE, taps3(16'h7FFF, 16'h7FFF, 16'h7FFF)));
        dir_tab.push_back(dir_col(8'd255, 8'd10, 8'd255, 1'b1, 1'b1, 8'd10, 8'd0));
        // mixed-sign kernel over a four-column line
        dir_tab.push_back(dir_wr(REG_COEFF_TOP, taps3(16'd1000, 16'd2000, -16'sd500)));
        dir_tab.push_back(dir_wr(REG_COEFF_MID, taps3(-16'sd3000, 16'd4096, 16'd5000)));
        dir_tab.push_back(dir_wr(REG_COEFF_BOT, taps3(16'd700, -16'sd1500, 16'd2500)));
        dir_tab.push_back(dir_col(8'd10, 8'd200, 8'd30, 1'b0, 1'b0, 8'd0, 8'd0));
        dir_tab.push_back(dir_col(8'd250, 8'd5, 8'd90, 1'b0, 1'b0, 8'd0, 8'd0));
        dir_tab.push_back(dir_col(8'd60, 8'd140, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0));
        dir_tab.push_back(dir_col(8'd255, 8'd70, 8'd180, 1'b1, 1'b0, 8'd0, 8'd0));

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_WRITE) begin
                drain_idle();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end else begin
                send_col(dir_tab[i].top, dir_tab[i].mid, dir_tab[i].bot, dir_tab[i].eol,
                         dir_tab[i].typed, dir_tab[i].p0, dir_tab[i].p1);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_idle();
            mode = ph % 4;
            src_idle_pct = (mode == 1) ? 53 : (mode == 3) ? 33 : 0;
            sink_stall_pct = (mode == 2) ? 53 : (mode == 3) ? 33 : 0;
            if (ph == 0) begin
                write_reg(REG_COEFF_TOP, COEFF_TOP_RST);
                write_reg(REG_COEFF_MID, COEFF_MID_RST);
                write_reg(REG_COEFF_BOT, COEFF_BOT_RST);
            end else if (ph == 5) begin
                write_reg(REG_COEFF_TOP, taps3(16'h7FFF, 16'h7FFF, 16'h7FFF));
                write_reg(REG_COEFF_MID, taps3(16'h8000, 16'h8000, 16'h8000));
                write_reg(REG_COEFF_BOT, taps3(16'h0000, 16'hFFFF, 16'h0001));
            end else begin
                write_reg(REG_COEFF_TOP, taps3(rand_tap(), rand_tap(), rand_tap()));
                write_reg(REG_COEFF_MID, taps3(rand_tap(), rand_tap(), rand_tap()));
                write_reg(REG_COEFF_BOT, taps3(rand_tap(), rand_tap(), rand_tap()));
            end
            send_lines(ITEMS_PER_PHASE);
        end

        drain_idle();
        repeat (20) @(posedge aclk);
        if (n_err == 0) begin
            $display("** conv3x3_line_filter: PASSED **");
        end else begin
            $display("** conv3x3_line_filter: FAILED **");
        end
        $finish;
    end

endmodule

FILE: conv3x3_line_filter.f
sv/c3lf_pkg.sv
sv/c3lf_fifo.sv
sv/c3lf_front.sv
sv/c3lf_back.sv
sv/conv3x3_line_filter.sv
sim/tb_top.sv
